// File: sv/pfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_pkg - shared types and constants of the page frame allocator
// Field widths, sequencer states, word operation codes and the result
// record of the shared word unit.
// ----------------------------------------------------------------------------
package pfba_pkg;

   localparam int MODE_W  = 2;
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 32;
   localparam int FADDR_W = 29;
   localparam int TOTAL_W = 18;
   localparam int FRAME_W = 20;   // frame number of a 32-bit byte address
   localparam int COUNT_W = 21;   // frame count, one above the largest frame
   localparam int WORD_W  = 32;
   localparam int BIT_W   = 5;
   localparam int PAGE_W  = 12;

   localparam int MAX_FRAME_COUNT_DEF = 131072;
   localparam int TOTAL_FRAMES_RESET  = 16384;

   localparam logic [MODE_W-1:0] MODE_ALLOC      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE_ONE   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESERVE    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FREE_RANGE = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_BOUND,
      ST_CHECK,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_SET,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] new_word;
      logic              hit;
      logic [BIT_W-1:0]  bit_idx;
   } wu_result_type;

endpackage
`default_nettype wire

// File: sv/pfba_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_req_if - request channel
// Valid/ready channel carrying one allocator command per beat.
// ----------------------------------------------------------------------------
interface pfba_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfba_pkg::MODE_W-1:0] mode;
   logic [pfba_pkg::ADDR_W-1:0] address;
   logic [pfba_pkg::SIZE_W-1:0] size_bytes;

   modport source (output valid, output mode, output address, output size_bytes,
                   input ready);
   modport sink   (input valid, input mode, input address, input size_bytes,
                   output ready);
endinterface
`default_nettype wire

// File: sv/pfba_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_rsp_if - response channel
// Valid/ready channel carrying one allocator result per beat.
// ----------------------------------------------------------------------------
interface pfba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pfba_pkg::FADDR_W-1:0] frame_address;
   logic                         found;

   modport source (output valid, output frame_address, output found, input ready);
   modport sink   (input valid, input frame_address, input found, output ready);
endinterface
`default_nettype wire

// File: sv/pfba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// File: sv/pfba_word_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfba_word_unit - shared bitmap word unit
// Builds the bit window [lo, hi] of one bitmap word, then sets or clears it,
// or finds the lowest clear bit inside it and marks that bit used.
// ----------------------------------------------------------------------------
module pfba_word_unit (
   input  wire pfba_pkg::op_type               op,
   input  wire logic [pfba_pkg::WORD_W-1:0]    data,
   input  wire logic [pfba_pkg::BIT_W-1:0]     lo,
   input  wire logic [pfba_pkg::BIT_W-1:0]     hi,
   output pfba_pkg::wu_result_type             res
);
   import pfba_pkg::*;

   localparam logic [WORD_W-1:0] ONES = '1;
   localparam logic [BIT_W-1:0]  TOP_BIT = BIT_W'(WORD_W - 1);

   logic [WORD_W-1:0] mask;
   logic [WORD_W-1:0] cand;
   logic [BIT_W-1:0]  low_bit;

   assign mask = (ONES << lo) & (ONES >> (TOP_BIT - hi));
   assign cand = ~data & mask;

   // lowest clear bit inside the window
   always_comb begin
      low_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (cand[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      res.hit     = |cand;
      res.bit_idx = low_bit;
      unique case (op)
         OP_ALLOC: res.new_word = data | (WORD_W'(1) << low_bit);
         OP_SET:   res.new_word = data | mask;
         OP_CLEAR: res.new_word = data & ~mask;
         default:  res.new_word = data;
      endcase
   end

endmodule
`default_nettype wire

// File: sv/page_frame_bitmap_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_top - first-fit bitmap page frame allocator
// One used bit per 4 KiB frame in a word RAM; a small sequencer walks the
// words through one shared word unit for allocate, free and range commands.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                          | handshake
//  ---------+-----------+----------------------------------+------------------
//  req_bus  | in        | mode, address, size_bytes        | valid/ready beat
//  rsp_bus  | out       | frame_address, found             | valid/ready beat
//  csr_*    | in        | csr_wdata = total_frames         | csr_we, no stall
//
//  A command passes from IDLE through SUM, BOUND and CHECK to SCAN, which
//  walks the bitmap words it touches (skipped for an empty range), then DONE:
//  allocate scans words from 0 up to the first with a free frame, ranges
//  walk first..last word; worst case is all MAX_FRAME_COUNT/32 words.
//  The single RAM read port feeds the walk one word per cycle.
//  After reset a fill pass writes all ones to every word (MAX_FRAME_COUNT/32
//  words, 4096 by default) while req_bus.ready stays low.
//  The response register holds a result until taken; a finished command waits
//  in DONE while that register is still full.
//
module page_frame_bitmap_allocator_top #(
   parameter int MAX_FRAME_COUNT = pfba_pkg::MAX_FRAME_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pfba_req_if.sink                           req_bus,
   pfba_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [pfba_pkg::TOTAL_W-1:0]  csr_wdata
);
   import pfba_pkg::*;

   localparam int WORD_COUNT = (MAX_FRAME_COUNT + WORD_W - 1) / WORD_W;
   localparam int WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam logic [WW-1:0]      LAST_WORD   = WW'(WORD_COUNT - 1);
   localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAME_COUNT);
   localparam int RESET_TOTAL =
      (TOTAL_FRAMES_RESET > MAX_FRAME_COUNT) ? MAX_FRAME_COUNT : TOTAL_FRAMES_RESET;

   // sequencer and command registers
   state_type            state_ff, state_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [ADDR_W-1:0]    sum_ff;
   logic [FRAME_W-1:0]   first_ff;
   logic [COUNT_W-1:0]   last_ff;      // one past the last frame touched
   logic [FRAME_W-1:0]   li_ff;        // last frame touched
   logic [TOTAL_W-1:0]   total_ff;

   // word walk
   logic [WW-1:0]        rd_ptr_ff;
   logic                 issue_done_ff;
   logic                 ev_valid_ff;
   logic [WW-1:0]        ev_ptr_ff;

   // result staging and response register
   logic [FADDR_W-1:0]   res_faddr_ff;
   logic                 res_found_ff;
   logic                 rsp_valid_ff;
   logic [FADDR_W-1:0]   rsp_faddr_ff;
   logic                 rsp_found_ff;

   // combinational control
   logic                 accept;
   logic                 range_ok;
   logic                 scan_finish;
   logic                 rsp_load;
   logic                 ram_we, ram_re;
   logic [WW-1:0]        ram_waddr;
   logic [WORD_W-1:0]    ram_wdata;
   logic [WORD_W-1:0]    ram_rdata;
   op_type               op;
   logic [WW-1:0]        first_w, limit_w;
   logic [BIT_W-1:0]     lo, hi;
   wu_result_type        wu;
   logic [COUNT_W-1:0]   total_c;
   logic [COUNT_W-1:0]   end_frame;
   logic [COUNT_W-1:0]   one_past;
   logic [FRAME_W-1:0]   hit_frame;

   assign total_c   = COUNT_W'(total_ff);
   assign first_w   = first_ff[BIT_W +: WW];
   assign limit_w   = li_ff[BIT_W +: WW];
   assign lo        = (ev_ptr_ff == first_w) ? first_ff[BIT_W-1:0] : '0;
   assign hi        = (ev_ptr_ff == limit_w) ? li_ff[BIT_W-1:0] : '1;
   // end of range rounded up to a page, 32-bit wrap kept in the frame number
   assign end_frame = COUNT_W'(FRAME_W'(sum_ff[ADDR_W-1:PAGE_W] +
                                        FRAME_W'(|sum_ff[PAGE_W-1:0])));
   assign one_past  = COUNT_W'(first_ff) + COUNT_W'(1);
   assign hit_frame = FRAME_W'({ev_ptr_ff, wu.bit_idx});

   always_comb begin
      unique case (mode_ff)
         MODE_ALLOC:   op = OP_ALLOC;
         MODE_RESERVE: op = OP_SET;
         default:      op = OP_CLEAR;
      endcase
   end

   pfba_word_unit u_word_unit (
      .op   (op),
      .data (ram_rdata),
      .lo   (lo),
      .hi   (hi),
      .res  (wu)
   );

   pfba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT),
      .AW    (WW)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   // range is empty when the end does not pass the start; a zero-size range
   // command does nothing at all
   assign range_ok = (last_ff > COUNT_W'(first_ff)) &&
                     !(mode_ff[1] && (size_ff == '0));

   // allocate stops at the first hit; every walk stops at its last word
   assign scan_finish = ev_valid_ff &&
                        (((op == OP_ALLOC) && wu.hit) || (ev_ptr_ff == limit_w));

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept   = req_bus.valid && req_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (rd_ptr_ff == LAST_WORD) state_in = ST_IDLE;
         ST_IDLE:  if (req_bus.valid) state_in = ST_SUM;
         ST_SUM:   state_in = ST_BOUND;
         ST_BOUND: state_in = ST_CHECK;
         ST_CHECK: state_in = range_ok ? ST_SCAN : ST_DONE;
         ST_SCAN:  if (scan_finish) state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_bus.ready = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = ev_ptr_ff;
      ram_wdata     = wu.new_word;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = rd_ptr_ff;
            ram_wdata = '1;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_SCAN: begin
            ram_re = !issue_done_ff && !scan_finish;
            ram_we = ev_valid_ff && ((op != OP_ALLOC) || wu.hit);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rd_ptr_ff     <= '0;
         issue_done_ff <= 1'b0;
         ev_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= TOTAL_W'(RESET_TOTAL);
      end else begin
         state_ff <= state_in;

         // saturate the frame count at the bitmap size
         if (csr_we) begin
            if (COUNT_W'(csr_wdata) > FRAME_LIMIT) begin
               total_ff <= TOTAL_W'(FRAME_LIMIT);
            end else begin
               total_ff <= csr_wdata;
            end
         end

         unique case (state_ff)
            ST_CLEAR: begin
               rd_ptr_ff <= rd_ptr_ff + WW'(1);
            end
            ST_CHECK: begin
               rd_ptr_ff     <= first_w;
               issue_done_ff <= 1'b0;
               ev_valid_ff   <= 1'b0;
            end
            ST_SCAN: begin
               // advance the read pointer, the eval stage follows one behind
               ev_valid_ff <= ram_re;
               if (ram_re) begin
                  if (rd_ptr_ff == limit_w) begin
                     issue_done_ff <= 1'b1;
                  end else begin
                     rd_ptr_ff <= rd_ptr_ff + WW'(1);
                  end
               end
            end
            default: begin
               ev_valid_ff <= 1'b0;
            end
         endcase

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_bus.mode;
         addr_ff <= req_bus.address;
         size_ff <= req_bus.size_bytes;
      end

      unique case (state_ff)
         ST_SUM: begin
            sum_ff   <= addr_ff + size_ff;
            first_ff <= (mode_ff == MODE_ALLOC) ? '0 : addr_ff[ADDR_W-1:PAGE_W];
         end
         ST_BOUND: begin
            // clip the end to the managed memory
            unique case (mode_ff)
               MODE_ALLOC:    last_ff <= total_c;
               MODE_FREE_ONE: last_ff <= (one_past < total_c) ? one_past : total_c;
               default:       last_ff <= (end_frame < total_c) ? end_frame : total_c;
            endcase
         end
         ST_CHECK: begin
            li_ff        <= FRAME_W'(last_ff - COUNT_W'(1));
            res_faddr_ff <= '0;
            // empty: allocate and free-one miss, ranges still report found
            res_found_ff <= range_ok ? (mode_ff != MODE_ALLOC) : mode_ff[1];
         end
         ST_SCAN: begin
            ev_ptr_ff <= rd_ptr_ff;
            if (scan_finish && (op == OP_ALLOC)) begin
               res_found_ff <= wu.hit;
               res_faddr_ff <= wu.hit ?
                  {hit_frame[FADDR_W-PAGE_W-1:0], {PAGE_W{1'b0}}} : '0;
            end
         end
         default: begin
            ev_ptr_ff <= ev_ptr_ff;
         end
      endcase

      if (rsp_load) begin
         rsp_faddr_ff <= res_faddr_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frame_address = rsp_faddr_ff;
   assign rsp_bus.found         = rsp_found_ff;

endmodule
`default_nettype wire
